@@ rtl/apob_pkg.sv @@
// Shared types and constants for the alpha-over pixel blend core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package apob_pkg;

   localparam logic [7:0] CHAN_MAX    = 8'hFF;
   localparam int         QUEUE_DEPTH = 2;
   localparam int         NUM_CHAN    = 3;

   // one input pixel pair
   typedef struct packed {
      logic [7:0] top_blue;
      logic [7:0] top_green;
      logic [7:0] top_red;
      logic [7:0] top_alpha;
      logic [7:0] bg_blue;
      logic [7:0] bg_green;
      logic [7:0] bg_red;
      logic [7:0] bg_alpha;
   } req_type;

   // one composited pixel
   typedef struct packed {
      logic [7:0] out_blue;
      logic [7:0] out_green;
      logic [7:0] out_red;
      logic [7:0] out_alpha;
   } rsp_type;

   // classified item handed from the front end to the back end
   typedef struct packed {
      logic [NUM_CHAN-1:0][7:0] top_col;
      logic [NUM_CHAN-1:0][7:0] bg_col;
      logic [15:0]              top_w;
      logic [15:0]              bg_w;
      logic [15:0]              final_w;
      logic                     zero;
      logic [7:0]               alpha;
   } work_type;

   // registered products ahead of the divider
   typedef struct packed {
      logic [NUM_CHAN-1:0][23:0] top_p;
      logic [NUM_CHAN-1:0][23:0] bg_p;
      logic [15:0]               divisor;
      logic                      zero;
      logic [NUM_CHAN-1:0][7:0]  bg_col;
      logic [7:0]                alpha;
   } prod_type;

   // one stage of the restoring divider
   typedef struct packed {
      logic [NUM_CHAN-1:0][23:0] rem;
      logic [NUM_CHAN-1:0][7:0]  quo;
      logic [15:0]               divisor;
      logic                      zero;
      logic [NUM_CHAN-1:0][7:0]  bg_col;
      logic [7:0]                alpha;
   } div_type;

endpackage
`default_nettype wire

@@ rtl/alpha_over_pixel_blend_core.sv @@
// Alpha-over compositing of BGRA pixel pairs: top level.
// Depends on apob_pkg, apob_front, apob_queue and apob_back.
//
// Usage:
//   req_*  : one top/background pixel pair per transfer (valid/stall).
//   rsp_*  : one composited pixel per transfer (valid/stall), in order.
//   csr_*  : write of force_opaque (bit 0), csr_ready is always high;
//            write only while no pixel is in flight.
// Throughput: one pixel per clock, sustained while rsp_stall is low.
// Path: rsp_valid rises once the pixel has passed the queue write, the
//   product stage, the sum stage and 8 divider stages of one quotient bit
//   each; the earliest rsp transfer is the edge after rsp_valid rises.
// When rsp_stall is high with a result waiting, the back-end pipe holds; the queue keeps taking
//   pixels until full, then req_stall rises.
// Reset: queue and pipe empty, force_opaque set to 1.
`timescale 1ns / 1ps
`default_nettype none
module alpha_over_pixel_blend_core #(
   parameter int QueueDepth = apob_pkg::QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire apob_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output apob_pkg::rsp_type      rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic              csr_data
);
   import apob_pkg::*;

   logic     force_opaque_ff;
   logic     q_full, q_not_empty, push, pop;
   work_type push_data, pop_data;

   assign csr_ready = 1'b1;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         force_opaque_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         force_opaque_ff <= csr_data;
      end
   end

   apob_front u_front (
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .force_opaque (force_opaque_ff),
      .q_full       (q_full),
      .push         (push),
      .push_data    (push_data)
   );

   apob_queue #(.Depth(QueueDepth)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .not_empty (q_not_empty),
      .pop_data  (pop_data)
   );

   apob_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_data      (pop_data),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
`default_nettype wire

@@ rtl/apob_queue.sv @@
// Small FIFO between the front end and the back end.
// Depends on apob_pkg for the work item type.
`timescale 1ns / 1ps
`default_nettype none
module apob_queue #(
   parameter int Depth = apob_pkg::QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire apob_pkg::work_type push_data,
   output logic                   full,
   input  wire logic              pop,
   output logic                   not_empty,
   output apob_pkg::work_type     pop_data
);
   import apob_pkg::*;

   localparam int PtrW = $clog2(Depth);
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   work_type            mem_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;

   assign full      = (count_ff == FullCnt);
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push || pop)
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue read while empty");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FullCnt)
      else $error("queue fill count out of range");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not follow a lone write");
`endif

endmodule
`default_nettype wire

@@ rtl/apob_front.sv @@
// Front end: accepts pixel pairs, forms the blend weights and output alpha.
// Depends on apob_pkg; feeds apob_queue.
`timescale 1ns / 1ps
`default_nettype none
module apob_front (
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire apob_pkg::req_type  req_data,
   input  wire logic               force_opaque,
   input  wire logic               q_full,
   output logic                    push,
   output apob_pkg::work_type      push_data
);
   import apob_pkg::*;

   logic [15:0] top_w;
   logic [15:0] bg_w;
   logic [15:0] final_w;
   logic [7:0]  inv_alpha;
   logic [16:0] div255;

   assign req_stall = q_full;
   assign push      = req_valid && !q_full;

   // weights: top = a*255, background = b*(255-a)
   always_comb begin
      inv_alpha = CHAN_MAX - req_data.top_alpha;
      top_w     = {req_data.top_alpha, 8'h00} - {8'h00, req_data.top_alpha};
      bg_w      = 16'(req_data.bg_alpha) * 16'(inv_alpha);
      final_w   = top_w + bg_w;
      // x/255 = (x + 1 + (x >> 8)) >> 8, exact for x below 65535
      div255    = {1'b0, final_w} + 17'(final_w[15:8]) + 17'd1;
   end

   // pack the item for the back end
   always_comb begin
      push_data.top_col = {req_data.top_red, req_data.top_green, req_data.top_blue};
      push_data.bg_col  = {req_data.bg_red, req_data.bg_green, req_data.bg_blue};
      push_data.top_w   = top_w;
      push_data.bg_w    = bg_w;
      push_data.final_w = final_w;
      push_data.zero    = (final_w == 16'd0);
      push_data.alpha   = force_opaque ? CHAN_MAX : div255[15:8];
   end

endmodule
`default_nettype wire

@@ rtl/apob_back.sv @@
// Back end: weighted sums and an 8-stage restoring divider, one quotient bit per stage.
// Depends on apob_pkg; drains apob_queue and drives the result channel.
`timescale 1ns / 1ps
`default_nettype none
module apob_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_not_empty,
   input  wire apob_pkg::work_type q_data,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output apob_pkg::rsp_type       rsp_data
);
   import apob_pkg::*;

   localparam int QuoBits = 8;
   localparam int NStage  = QuoBits + 2;

   logic [NStage-1:0] valid_ff, valid_in;
   prod_type          prod_ff, prod_in;
   div_type           div_ff [QuoBits+1];
   div_type           div_in [QuoBits+1];
   logic              advance;

   // whole pipe moves unless the finished result is held
   assign advance   = !(valid_ff[NStage-1] && rsp_stall);
   assign pop       = advance && q_not_empty;
   assign rsp_valid = valid_ff[NStage-1];
   assign valid_in  = {valid_ff[NStage-2:0], q_not_empty};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // products of color and weight
   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         prod_in.top_p[c] = 24'(q_data.top_col[c]) * 24'(q_data.top_w);
         prod_in.bg_p[c]  = 24'(q_data.bg_col[c]) * 24'(q_data.bg_w);
      end
      prod_in.divisor = q_data.final_w;
      prod_in.zero    = q_data.zero;
      prod_in.bg_col  = q_data.bg_col;
      prod_in.alpha   = q_data.alpha;
   end

   // sum into the dividend
   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         div_in[0].rem[c] = prod_ff.top_p[c] + prod_ff.bg_p[c];
         div_in[0].quo[c] = '0;
      end
      div_in[0].divisor = prod_ff.divisor;
      div_in[0].zero    = prod_ff.zero;
      div_in[0].bg_col  = prod_ff.bg_col;
      div_in[0].alpha   = prod_ff.alpha;
   end

   // each stage resolves one quotient bit, most significant first
   for (genvar k = 1; k <= QuoBits; k++) begin : g_div
      localparam int Shift = QuoBits - k;
      always_comb begin
         logic [23:0] trial;
         div_in[k] = div_ff[k-1];
         trial     = 24'(div_ff[k-1].divisor) << Shift;
         for (int c = 0; c < NUM_CHAN; c++) begin
            if (div_ff[k-1].rem[c] >= trial) begin
               div_in[k].rem[c]        = div_ff[k-1].rem[c] - trial;
               div_in[k].quo[c][Shift] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         for (int k = 0; k <= QuoBits; k++) begin
            div_ff[k] <= div_in[k];
         end
      end
   end

   // zero weight passes the background color through
   always_comb begin
      rsp_data.out_blue  = div_ff[QuoBits].zero ? div_ff[QuoBits].bg_col[0]
                                                : div_ff[QuoBits].quo[0];
      rsp_data.out_green = div_ff[QuoBits].zero ? div_ff[QuoBits].bg_col[1]
                                                : div_ff[QuoBits].quo[1];
      rsp_data.out_red   = div_ff[QuoBits].zero ? div_ff[QuoBits].bg_col[2]
                                                : div_ff[QuoBits].quo[2];
      rsp_data.out_alpha = div_ff[QuoBits].alpha;
   end

endmodule
`default_nettype wire

@@ test/apob_checker.sv @@
// Checker for the alpha-over pixel blend core: watches req/rsp/csr transfers,
// predicts each composited pixel and compares in order. Depends on apob_pkg.
`timescale 1ns / 1ps
module apob_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  apob_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  apob_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic              csr_data,
   output int                fail_count,
   output int                pending
);
   import apob_pkg::*;

   logic    opaque_mode;
   rsp_type pixel_queue[$];

   // composite one pixel pair with the current alpha mode
   function automatic rsp_type blend_pixel(req_type p, logic opaque);
      rsp_type r;
      int unsigned top_w, bg_w, fin_w;
      top_w = p.top_alpha * 255;
      bg_w  = p.bg_alpha * (255 - p.top_alpha);
      fin_w = top_w + bg_w;
      if (fin_w == 0) begin
         r.out_blue  = p.bg_blue;
         r.out_green = p.bg_green;
         r.out_red   = p.bg_red;
      end else begin
         r.out_blue  = 8'((p.bg_blue * bg_w + p.top_blue * top_w) / fin_w);
         r.out_green = 8'((p.bg_green * bg_w + p.top_green * top_w) / fin_w);
         r.out_red   = 8'((p.bg_red * bg_w + p.top_red * top_w) / fin_w);
      end
      r.out_alpha = opaque ? CHAN_MAX : 8'(fin_w / 255);
      return r;
   endfunction

   assign pending = pixel_queue.size();

   always @(posedge clock) begin
      rsp_type want;
      int      errs;
      errs = 0;
      if (reset) begin
         opaque_mode <= 1'b1;
         pixel_queue.delete();
         fail_count  <= 0;
      end else begin
         if (csr_valid && csr_ready) opaque_mode <= csr_data;
         if (req_valid && !req_stall)
            pixel_queue.push_back(blend_pixel(req_data, opaque_mode));
         if (rsp_valid && !rsp_stall) begin
            if (pixel_queue.size() == 0) begin
               $error("unexpected rsp transfer: %h", rsp_data);
               errs++;
            end else begin
               want = pixel_queue.pop_front();
               if (rsp_data.out_blue !== want.out_blue) begin
                  $error("out_blue exp %0d got %0d", want.out_blue, rsp_data.out_blue);
                  errs++;
               end
               if (rsp_data.out_green !== want.out_green) begin
                  $error("out_green exp %0d got %0d", want.out_green, rsp_data.out_green);
                  errs++;
               end
               if (rsp_data.out_red !== want.out_red) begin
                  $error("out_red exp %0d got %0d", want.out_red, rsp_data.out_red);
                  errs++;
               end
               if (rsp_data.out_alpha !== want.out_alpha) begin
                  $error("out_alpha exp %0d got %0d", want.out_alpha, rsp_data.out_alpha);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
   end
endmodule

@@ test/testbench.sv @@
// Testbench top for alpha_over_pixel_blend_core: drives pixel pairs, stalls
// and csr writes; apob_checker does the prediction. Depends on apob_pkg.
`timescale 1ns / 1ps
module testbench;
   import apob_pkg::*;

   localparam int LATENCY   = 11;
   localparam int MAX_CYCLE = 400000;

   logic    clock = 0, reset = 1;
   logic    req_valid = 0, req_stall;
   req_type req_data = '0;
   logic    rsp_valid, rsp_stall = 0;
   rsp_type rsp_data;
   logic    csr_valid = 0, csr_ready, csr_data = 0;
   int      fail_count, pending;
   int      cycle = 0;
   bit      hold_off = 0;

   alpha_over_pixel_blend_core uut (.*);

   apob_checker u_checker (.*);

   initial forever #5 clock = ~clock;

   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > MAX_CYCLE) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // receiver stall pattern, with one long hold-off on request
   initial begin
      int mode;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (60) @(posedge clock);
            hold_off = 0;
         end
         mode = (cycle / 500) % 3;
         if (mode == 0) rsp_stall <= 1'b0;
         else if (mode == 1) rsp_stall <= ($urandom_range(0, 3) == 0);
         else rsp_stall <= ($urandom_range(0, 1) == 0);
      end
   end

   // offer one pixel pair; random burst gaps come from the caller
   task automatic send_pixel(input req_type p);
      req_valid <= 1'b1;
      req_data  <= p;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic idle_gap(input int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   function automatic req_type random_pixel();
      req_type p;
      int pick;
      p = req_type'({$urandom, $urandom});
      pick = $urandom_range(0, 9);
      // favor the alpha extremes, zero weight included
      if (pick == 0) p.top_alpha = 8'd0;
      if (pick == 1) p.top_alpha = 8'd255;
      if (pick == 2) p.bg_alpha = 8'd0;
      if (pick == 3) begin p.top_alpha = 8'd0; p.bg_alpha = 8'd0; end
      return p;
   endfunction

   task automatic drain();
      idle_gap(1);
      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_opaque(input logic v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_phase(input int count);
      int burst;
      while (count > 0) begin
         burst = $urandom_range(1, 20);
         while (burst > 0 && count > 0) begin
            send_pixel(random_pixel());
            burst--; count--;
         end
         idle_gap($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6));
      end
   endtask

   initial begin
      req_type p;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes with reset mode (opaque), then coverage mode
      for (int m = 0; m < 2; m++) begin
         if (m == 1) write_opaque(1'b0);
         send_pixel('0);                                   // zero weight
         send_pixel('1);                                   // all full
         p = '1; p.top_alpha = 8'd0; p.bg_alpha = 8'd0; send_pixel(p);
         p = '0; p.top_alpha = 8'd255; send_pixel(p);
         p = '1; p.top_alpha = 8'd0; p.bg_blue = 8'h12; send_pixel(p);
         p = req_type'(64'hFF00_FF80_00FF_0001); send_pixel(p);
         p = req_type'(64'h00FF_0001_FF00_FF7F); send_pixel(p);
         p = req_type'(64'hAA55_AA01_55AA_55FE); send_pixel(p);
         p = req_type'(64'h55AA_55FE_AA55_AA01); send_pixel(p);
         drain();
      end

      random_phase(600);
      drain();
      write_opaque(1'b1);
      // pressure: long receiver hold-off while the sender keeps offering
      hold_off = 1;
      random_phase(700);
      drain();
      write_opaque(1'b0);
      random_phase(600);
      drain();

      if (fail_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

@@ sim.f @@
rtl/apob_pkg.sv
rtl/apob_queue.sv
rtl/apob_front.sv
rtl/apob_back.sv
rtl/alpha_over_pixel_blend_core.sv
test/apob_checker.sv
test/testbench.sv
